// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pctf_pkg.sv =====
// shared constants and register codes for the two-form pid controller
package pctf_pkg;

	// sample, gain and accumulator sizing
	localparam int SAMPLE_WIDTH   = 16;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int ACC_WIDTH      = 32;
	localparam int GAIN_W         = 16;
	localparam int OUT_W          = 32;
	localparam int LIM_W          = 32;
	localparam int SEP_W          = 17;
	localparam int SEPWIN_W       = 2 * SEP_W;

	// derived datapath widths
	localparam int ERR_W = SAMPLE_WIDTH + 1;
	localparam int INT_W = (ACC_WIDTH > LIM_W) ? ACC_WIDTH : LIM_W;
	localparam int CMP_W = (ERR_W > SEP_W) ? ERR_W : SEP_W;
	localparam int OPP_W = ERR_W + 1;
	localparam int OPD_W = ERR_W + 2;
	localparam int OPI_W = (INT_W > ERR_W) ? INT_W : ERR_W;
	localparam int PRP_W = GAIN_W + OPP_W;
	localparam int PRD_W = GAIN_W + OPD_W;
	localparam int PRI_W = GAIN_W + OPI_W;
	localparam int SCP_W = PRP_W - GAIN_FRAC_BITS;
	localparam int SCD_W = PRD_W - GAIN_FRAC_BITS;
	localparam int SCI_W = PRI_W - GAIN_FRAC_BITS;
	localparam int SUM_W = ((SCI_W > OUT_W) ? SCI_W : OUT_W) + 3;

	// apb port
	localparam int PADDR_W   = 6;
	localparam int PDATA_W   = 64;
	localparam int REG_IDX_W = PADDR_W - 3;

	// register map, 8-byte stride
	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_P        = 3'd0,
		REG_GAIN_I        = 3'd1,
		REG_GAIN_D        = 3'd2,
		REG_SEP_WINDOW    = 3'd3,
		REG_INTEGRAL_LOW  = 3'd4,
		REG_INTEGRAL_HIGH = 3'd5,
		REG_OUTPUT_LOW    = 3'd6,
		REG_OUTPUT_HIGH   = 3'd7
	} reg_idx_t;

	// form select
	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

endpackage

// ===== src/pid_controller_two_form.sv =====
// two-form pid controller: apb register file and four-stage datapath
// an accepted word passes the operand, product and result registers on to out_valid
// throughput: one word per cycle unless stalled; output_prev loops within the last stage
// stages: input register, error and integral update, three gain multiplies, sum and clamp
// a stall on the output holds every stage; in_ready follows the output register
// reset: arst_n clears the apb registers, state, and valid flags; gain writes clear the state
module pid_controller_two_form
	import pctf_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	// apb configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [PADDR_W-1:0]              paddr,
	input  logic [PDATA_W-1:0]              pwdata,
	output logic [PDATA_W-1:0]              prdata,
	output logic                            pready,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic signed [SAMPLE_WIDTH-1:0]  setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0]  measured,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [OUT_W-1:0]         control_value
);

	localparam logic signed [INT_W:0] ACC_MAX =
		(INT_W+1)'((64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1);
	localparam logic signed [INT_W:0] ACC_MIN = -ACC_MAX - 1;
	localparam logic signed [SUM_W-1:0] OUT_MAX =
		SUM_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] OUT_MIN = -OUT_MAX - 1;

	// configuration registers
	logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [SEPWIN_W-1:0]       sep_window_q;
	logic signed [LIM_W-1:0]   integral_low_q, integral_high_q;
	logic signed [LIM_W-1:0]   output_low_q, output_high_q;

	// controller state
	logic signed [INT_W-1:0]   integral_sum_q;
	logic signed [ERR_W-1:0]   error_prev_q, error_older_q;
	logic signed [OUT_W-1:0]   output_prev_q;

	// pipeline
	logic                      adv;
	logic                      vld_s1, vld_s2, vld_s3;
	logic                      mode_s1, mode_s2, mode_s3;
	logic signed [SAMPLE_WIDTH-1:0] setpoint_s1, measured_s1;
	logic signed [OPP_W-1:0]   op_p_s2;
	logic signed [OPI_W-1:0]   op_i_s2;
	logic signed [OPD_W-1:0]   op_d_s2;
	logic                      use_i_s2;
	logic signed [SCP_W-1:0]   sc_p_s3;
	logic signed [SCI_W-1:0]   sc_i_s3;
	logic signed [SCD_W-1:0]   sc_d_s3;
	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   control_value_q;

	// apb decode
	logic      cfg_wr;
	logic      gain_wr;
	reg_idx_t  reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign gain_wr = cfg_wr &
		(reg_idx == REG_GAIN_P || reg_idx == REG_GAIN_I || reg_idx == REG_GAIN_D);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q        <= '0;
			gain_i_q        <= '0;
			gain_d_q        <= '0;
			sep_window_q    <= '0;
			integral_low_q  <= '0;
			integral_high_q <= '0;
			output_low_q    <= '0;
			output_high_q   <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_GAIN_P:        gain_p_q        <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:        gain_i_q        <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:        gain_d_q        <= pwdata[GAIN_W-1:0];
				REG_SEP_WINDOW:    sep_window_q    <= pwdata[SEPWIN_W-1:0];
				REG_INTEGRAL_LOW:  integral_low_q  <= pwdata[LIM_W-1:0];
				REG_INTEGRAL_HIGH: integral_high_q <= pwdata[LIM_W-1:0];
				REG_OUTPUT_LOW:    output_low_q    <= pwdata[LIM_W-1:0];
				REG_OUTPUT_HIGH:   output_high_q   <= pwdata[LIM_W-1:0];
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_GAIN_P:        prdata = PDATA_W'($unsigned(gain_p_q));
			REG_GAIN_I:        prdata = PDATA_W'($unsigned(gain_i_q));
			REG_GAIN_D:        prdata = PDATA_W'($unsigned(gain_d_q));
			REG_SEP_WINDOW:    prdata = PDATA_W'(sep_window_q);
			REG_INTEGRAL_LOW:  prdata = PDATA_W'($unsigned(integral_low_q));
			REG_INTEGRAL_HIGH: prdata = PDATA_W'($unsigned(integral_high_q));
			REG_OUTPUT_LOW:    prdata = PDATA_W'($unsigned(output_low_q));
			REG_OUTPUT_HIGH:   prdata = PDATA_W'($unsigned(output_high_q));
		endcase
	end

	// whole pipeline moves when the output register is free or being taken
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			out_valid_q <= vld_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1     <= mode;
			setpoint_s1 <= setpoint;
			measured_s1 <= measured;
		end
	end

	// stage 1: error, separation window, integral update
	logic signed [ERR_W-1:0]   err;
	logic signed [CMP_W-1:0]   err_c, sep_lo_c, sep_hi_c;
	logic                      use_i;
	logic signed [INT_W:0]     int_raw, int_sat, int_lo_c, int_hi_c;
	logic signed [INT_W-1:0]   int_nxt;

	always_comb begin
		err      = ERR_W'(setpoint_s1) - ERR_W'(measured_s1);
		err_c    = CMP_W'(err);
		sep_lo_c = CMP_W'($signed(sep_window_q[SEP_W-1:0]));
		sep_hi_c = CMP_W'($signed(sep_window_q[SEPWIN_W-1:SEP_W]));
		use_i    = 1'b1;
		if ((sep_lo_c != '0 && err_c < 0 && err_c < sep_lo_c) ||
		    (sep_hi_c != '0 && err_c > 0 && err_c > sep_hi_c)) begin
			use_i = 1'b0;
		end

		// saturating add, then low clamp with priority over high clamp
		int_raw  = (INT_W+1)'(integral_sum_q) + (INT_W+1)'(err);
		int_lo_c = (INT_W+1)'(integral_low_q);
		int_hi_c = (INT_W+1)'(integral_high_q);
		if (int_raw > ACC_MAX) begin
			int_sat = ACC_MAX;
		end else if (int_raw < ACC_MIN) begin
			int_sat = ACC_MIN;
		end else begin
			int_sat = int_raw;
		end
		priority if (integral_low_q != '0 && int_sat < int_lo_c) begin
			int_nxt = INT_W'(integral_low_q);
		end else if (integral_high_q != '0 && int_sat > int_hi_c) begin
			int_nxt = INT_W'(integral_high_q);
		end else begin
			int_nxt = int_sat[INT_W-1:0];
		end
	end

	// integral and error history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_sum_q <= '0;
			error_prev_q   <= '0;
			error_older_q  <= '0;
		end else if (gain_wr) begin
			integral_sum_q <= '0;
			error_prev_q   <= '0;
			error_older_q  <= '0;
		end else if (adv && vld_s1) begin
			if (mode_s1 == MODE_POSITIONAL) begin
				integral_sum_q <= int_nxt;
				error_older_q  <= err;
			end else begin
				error_older_q  <= error_prev_q;
				error_prev_q   <= err;
			end
		end
	end

	// multiplier operands for both forms
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_s1;
			if (mode_s1 == MODE_INCREMENTAL) begin
				op_p_s2  <= OPP_W'(err) - OPP_W'(error_prev_q);
				op_i_s2  <= OPI_W'(err);
				// err + older - twice prev
				op_d_s2  <= OPD_W'(err) + OPD_W'(error_older_q) - (OPD_W'(error_prev_q) <<< 1);
				use_i_s2 <= 1'b1;
			end else begin
				op_p_s2  <= OPP_W'(err);
				op_i_s2  <= OPI_W'(int_nxt);
				op_d_s2  <= OPD_W'(err) - OPD_W'(error_older_q);
				use_i_s2 <= use_i;
			end
		end
	end

	// stage 2: gain products, arithmetic shift gives floor
	logic signed [PRP_W-1:0] prod_p;
	logic signed [PRI_W-1:0] prod_i;
	logic signed [PRD_W-1:0] prod_d;

	assign prod_p = gain_p_q * op_p_s2;
	assign prod_i = gain_i_q * op_i_s2;
	assign prod_d = gain_d_q * op_d_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3 <= mode_s2;
			sc_p_s3 <= prod_p[PRP_W-1:GAIN_FRAC_BITS];
			sc_d_s3 <= prod_d[PRD_W-1:GAIN_FRAC_BITS];
			sc_i_s3 <= use_i_s2 ? prod_i[PRI_W-1:GAIN_FRAC_BITS] : '0;
		end
	end

	// stage 3: sum, saturate, output clamps
	logic signed [SUM_W-1:0] sum;
	logic signed [OUT_W-1:0] res_sat, res_clamp;

	always_comb begin
		sum = SUM_W'(sc_p_s3) + SUM_W'(sc_i_s3) + SUM_W'(sc_d_s3);
		if (mode_s3 == MODE_INCREMENTAL) begin
			sum = sum + SUM_W'(output_prev_q);
		end
		if (sum > OUT_MAX) begin
			res_sat = OUT_MAX[OUT_W-1:0];
		end else if (sum < OUT_MIN) begin
			res_sat = OUT_MIN[OUT_W-1:0];
		end else begin
			res_sat = sum[OUT_W-1:0];
		end
		res_clamp = res_sat;
		if (output_low_q != '0 && res_clamp < output_low_q) begin
			res_clamp = output_low_q;
		end
		if (output_high_q != '0 && res_clamp > output_high_q) begin
			res_clamp = output_high_q;
		end
	end

	// unclamped incremental output feedback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_prev_q <= '0;
		end else if (gain_wr) begin
			output_prev_q <= '0;
		end else if (adv && vld_s3 && mode_s3 == MODE_INCREMENTAL) begin
			output_prev_q <= res_sat;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv) begin
			control_value_q <= res_clamp;
		end
	end

	assign out_valid     = out_valid_q;
	assign control_value = control_value_q;

endmodule

// ===== src/pctf_checker.sv =====
// port-level checker for the two-form pid controller, bound to the top level
`include "assert_macros.svh"

module pctf_checker
	import pctf_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic signed [OUT_W-1:0]         control_value
);

	// a waiting result word holds
	`CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(control_value), "result word changed while stalled")

	// input side only stalls behind a blocked result
	`CHK_SAME(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

	// an accepted word reaches the output if out_ready holds while it moves down the pipeline
	`CHK_NEXT(a_latency, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid, "result word missing after pipeline latency")

endmodule

bind pid_controller_two_form pctf_checker u_pctf_checker (.*);

// ===== dv/tb_pid_controller_two_form.sv =====
// testbench for the two-form pid controller: directed and random samples checked against a predictor
`timescale 1ns / 1ps

module tb_pid_controller_two_form;
	import pctf_pkg::*;

	localparam int     CYCLE_LIMIT  = 800000;
	localparam int     DRAIN_CYCLES = 8;
	localparam int     REPORT_MAX   = 10;
	localparam longint DIFF_FACTOR  = 2;
	localparam int     SAT_RUN      = 40;

	// tracks the controller state and holds the control words still owed by the block
	class control_tracker;
		longint kp, ki, kd;
		longint sep_lo, sep_hi;
		longint int_lo, int_hi, out_lo, out_hi;
		longint integral_acc, err_latest, err_before, out_running;
		logic signed [OUT_W-1:0] expected_controls[$];
		int mismatches;

		function void clear_history();
			integral_acc = 0;
			err_latest   = 0;
			err_before   = 0;
			out_running  = 0;
		endfunction

		function void apply_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_GAIN_P: begin
					kp = longint'($signed(value[GAIN_W-1:0]));
					clear_history();
				end
				REG_GAIN_I: begin
					ki = longint'($signed(value[GAIN_W-1:0]));
					clear_history();
				end
				REG_GAIN_D: begin
					kd = longint'($signed(value[GAIN_W-1:0]));
					clear_history();
				end
				REG_SEP_WINDOW: begin
					sep_lo = longint'($signed(value[SEP_W-1:0]));
					sep_hi = longint'($signed(value[SEPWIN_W-1:SEP_W]));
				end
				REG_INTEGRAL_LOW:  int_lo = longint'($signed(value[LIM_W-1:0]));
				REG_INTEGRAL_HIGH: int_hi = longint'($signed(value[LIM_W-1:0]));
				REG_OUTPUT_LOW:    out_lo = longint'($signed(value[LIM_W-1:0]));
				REG_OUTPUT_HIGH:   out_hi = longint'($signed(value[LIM_W-1:0]));
				default: ;
			endcase
		endfunction

		function longint saturate(longint x, int w);
			longint hi, lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			if (x > hi) return hi;
			if (x < lo) return lo;
			return x;
		endfunction

		// q8.8 product, floor shift
		function longint scale_gain(longint g, longint v);
			return (g * v) >>> GAIN_FRAC_BITS;
		endfunction

		function void note_sample(logic m, logic signed [SAMPLE_WIDTH-1:0] sp,
				logic signed [SAMPLE_WIDTH-1:0] ms);
			longint e, res;
			bit drop_i;
			e = longint'(sp) - longint'(ms);
			if (m == MODE_POSITIONAL) begin
				// separation window decides whether the integral term counts
				drop_i = (sep_lo != 0 && e < 0 && e < sep_lo) ||
					(sep_hi != 0 && e > 0 && e > sep_hi);
				integral_acc = saturate(integral_acc + e, ACC_WIDTH);
				if (int_lo != 0 && integral_acc < int_lo)
					integral_acc = int_lo;
				else if (int_hi != 0 && integral_acc > int_hi)
					integral_acc = int_hi;
				res = scale_gain(kp, e) + scale_gain(kd, e - err_before);
				if (!drop_i)
					res += scale_gain(ki, integral_acc);
				res = saturate(res, OUT_W);
				err_before = e;
			end else begin
				res = out_running + scale_gain(kp, e - err_latest) + scale_gain(ki, e) +
					scale_gain(kd, e + err_before - DIFF_FACTOR * err_latest);
				res = saturate(res, OUT_W);
				out_running = res;
				err_before  = err_latest;
				err_latest  = e;
			end
			// output clamps, low then high
			if (out_lo != 0 && res < out_lo) res = out_lo;
			if (out_hi != 0 && res > out_hi) res = out_hi;
			expected_controls.push_back(res[OUT_W-1:0]);
		endfunction

		function void check_control(logic signed [OUT_W-1:0] got);
			logic signed [OUT_W-1:0] want;
			if (expected_controls.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected control word %0d", got);
				return;
			end
			want = expected_controls.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("control_value mismatch: expected %0d actual %0d", want, got);
			end
		endfunction
	endclass

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            psel      = 1'b0;
	logic                            penable   = 1'b0;
	logic                            pwrite    = 1'b0;
	logic [PADDR_W-1:0]              paddr     = '0;
	logic [PDATA_W-1:0]              pwdata    = '0;
	logic [PDATA_W-1:0]              prdata;
	logic                            pready;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	logic                            mode      = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0]  setpoint  = '0;
	logic signed [SAMPLE_WIDTH-1:0]  measured  = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic signed [OUT_W-1:0]         control_value;

	control_tracker tracker = new;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cycle_count = 0;

	pid_controller_two_form u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.setpoint      (setpoint),
		.measured      (measured),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.control_value (control_value)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// check every accepted control word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_control(control_value);
	end

	// offer one word, with random idle cycles first
	task automatic send_sample(logic m, logic signed [SAMPLE_WIDTH-1:0] sp,
			logic signed [SAMPLE_WIDTH-1:0] ms);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		setpoint <= sp;
		measured <= ms;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.note_sample(m, sp, ms);
	endtask

	// apb write: setup, access, then psel and penable released before returning
	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.apply_write(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every owed word has come back and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.expected_controls.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PDATA_W-1:0] noisy(logic [PDATA_W-1:0] v, int w);
		logic [PDATA_W-1:0] r;
		r = {$urandom(), $urandom()};
		r = (r >> w) << w;
		return r | (v & ((64'd1 << w) - 1));
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return '0;
			3: return GAIN_W'($urandom_range(512));
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	function automatic logic [SEP_W-1:0] pick_threshold(bit negative);
		case ($urandom_range(3))
			0: return '0;
			1: return negative ? SEP_W'(-$urandom_range(1, 40000)) : SEP_W'($urandom_range(1, 40000));
			2: return negative ? 17'h10000 : 17'h0ffff;
			default: return SEP_W'($urandom());
		endcase
	endfunction

	task automatic pick_limits(output logic [LIM_W-1:0] lo, output logic [LIM_W-1:0] hi);
		case ($urandom_range(4))
			0: begin
				lo = '0;
				hi = '0;
			end
			1: begin
				lo = -$urandom_range(1, 1 << 20);
				hi = $urandom_range(1, 1 << 20);
			end
			2: begin
				lo = 32'h8000_0000;
				hi = 32'h7fff_ffff;
			end
			3: begin
				lo = $urandom();
				hi = $urandom();
			end
			default: begin
				lo = -$urandom_range(1, 5000);
				hi = '0;
			end
		endcase
	endtask

	function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2, 3: return SAMPLE_WIDTH'($urandom_range(600) - 300);
			default: return SAMPLE_WIDTH'($urandom());
		endcase
	endfunction

	// new register setting; gains only sometimes so history can carry over
	task automatic random_setting(bit with_gains);
		logic [LIM_W-1:0] lo, hi;
		if (with_gains) begin
			write_reg(REG_GAIN_P, noisy(pick_gain(), GAIN_W));
			write_reg(REG_GAIN_I, noisy(pick_gain(), GAIN_W));
			write_reg(REG_GAIN_D, noisy(pick_gain(), GAIN_W));
		end
		write_reg(REG_SEP_WINDOW, noisy({pick_threshold(1'b0), pick_threshold(1'b1)}, SEPWIN_W));
		pick_limits(lo, hi);
		write_reg(REG_INTEGRAL_LOW, noisy(lo, LIM_W));
		write_reg(REG_INTEGRAL_HIGH, noisy(hi, LIM_W));
		pick_limits(lo, hi);
		write_reg(REG_OUTPUT_LOW, noisy(lo, LIM_W));
		write_reg(REG_OUTPUT_HIGH, noisy(hi, LIM_W));
	endtask

	initial begin
		int bias;
		logic m;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset setting, then moderate gains with all limits active
		tx_idle_pct = 12;
		rx_idle_pct = 82;
		send_sample(MODE_POSITIONAL, 16'sd7, 16'sd3);
		drain();
		write_reg(REG_GAIN_P, 64'd256);
		write_reg(REG_GAIN_I, 64'd1);
		write_reg(REG_GAIN_D, 64'hffff);
		write_reg(REG_SEP_WINDOW, {17'd1000, 17'h1fc18});
		write_reg(REG_INTEGRAL_LOW, 64'hffff_ffff_fffe_7960);
		write_reg(REG_INTEGRAL_HIGH, 64'd100000);
		write_reg(REG_OUTPUT_LOW, 64'h0000_0000_ffff_3cb0);
		write_reg(REG_OUTPUT_HIGH, 64'd50000);
		send_sample(MODE_POSITIONAL, 16'sh7fff, 16'sh8000);
		send_sample(MODE_POSITIONAL, 16'sh8000, 16'sh7fff);
		send_sample(MODE_POSITIONAL, 16'sd0, 16'sd0);
		send_sample(MODE_POSITIONAL, 16'sd500, 16'sd0);
		send_sample(MODE_INCREMENTAL, 16'sh7fff, 16'sh8000);
		send_sample(MODE_INCREMENTAL, 16'sh8000, 16'sh7fff);
		send_sample(MODE_INCREMENTAL, 16'sd0, 16'sd0);
		send_sample(MODE_POSITIONAL, 16'sd100, -16'sd100);
		send_sample(MODE_INCREMENTAL, 16'sd1, 16'sd0);
		send_sample(MODE_POSITIONAL, 16'sh8000, 16'sh8000);
		send_sample(MODE_INCREMENTAL, 16'sh7fff, 16'sh7fff);
		drain();

		// directed: extreme gains, nothing clamped, output overflow both ways
		write_reg(REG_GAIN_P, 64'h7fff);
		write_reg(REG_GAIN_I, 64'h8000);
		write_reg(REG_GAIN_D, 64'h7fff);
		write_reg(REG_SEP_WINDOW, 64'd0);
		write_reg(REG_INTEGRAL_LOW, 64'd0);
		write_reg(REG_INTEGRAL_HIGH, 64'd0);
		write_reg(REG_OUTPUT_LOW, 64'd0);
		write_reg(REG_OUTPUT_HIGH, 64'd0);
		repeat (5) send_sample(MODE_INCREMENTAL, 16'sh8000, 16'sh7fff);
		repeat (5) send_sample(MODE_INCREMENTAL, 16'sh7fff, 16'sh8000);
		send_sample(MODE_POSITIONAL, 16'sh7fff, 16'sh8000);
		send_sample(MODE_POSITIONAL, 16'sh8000, 16'sh7fff);
		drain();

		// integral ramp, up then down, at full rate
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(REG_GAIN_P, 64'd0);
		write_reg(REG_GAIN_D, 64'd0);
		write_reg(REG_GAIN_I, 64'd1);
		repeat (SAT_RUN) send_sample(MODE_POSITIONAL, 16'sh7fff, 16'sh8000);
		drain();
		write_reg(REG_GAIN_I, 64'd1);
		repeat (SAT_RUN) send_sample(MODE_POSITIONAL, 16'sh8000, 16'sh7fff);
		drain();

		// random: three idling profiles, four settings each
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 12;
					rx_idle_pct = 82;
				end
				1: begin
					tx_idle_pct = 82;
					rx_idle_pct = 12;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				drain();
				random_setting((blk == 0) || ($urandom_range(1) == 1));
				bias = $urandom_range(2);
				repeat (90) begin
					case (bias)
						0: m = MODE_POSITIONAL;
						1: m = MODE_INCREMENTAL;
						default: m = $urandom_range(1);
					endcase
					send_sample(m, pick_sample(), pick_sample());
				end
			end
		end
		drain();

		if (tracker.mismatches == 0 && tracker.expected_controls.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
